>>> src/ssjh_pkg.sv
// shared constants, types and hash functions for the splat stroke jitter hash core
package ssjh_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SQRT_STAGES = 24;
   localparam int DIV_STAGES  = 17;
   localparam int PIPE_DEPTH  = 2 + SQRT_STAGES + DIV_STAGES + 4;
   localparam int FRONT_DLY   = PIPE_DEPTH - 9;

   localparam logic [31:0] GOLDEN     = 32'h9E37_79B9;
   localparam logic [31:0] LVL_MUL    = 32'd2654435761;
   localparam logic [31:0] SALT_NOISE = 32'h9E37_79B9;
   localparam logic [31:0] SALT_JIT   = 32'h7F4A_7C15;
   localparam logic [31:0] SALT_ANG   = 32'hA511_E9B3;
   localparam logic [31:0] SALT_SCL   = 32'h6C8E_9CF5;
   localparam logic [31:0] SALT_JY    = 32'h0005_1633;

   localparam logic [23:0] UNIT_DIV      = 24'hFF_FFFF;
   localparam logic [23:0] HALF_UNIT_DIV = 24'h7F_FFFF;

   localparam logic [16:0] ONE_F   = 17'd65536;
   localparam logic [18:0] PI_F    = 19'd205887;
   localparam logic [18:0] TAU_F   = 19'd411775;
   localparam logic [16:0] SIX_F   = 17'd39322;
   localparam logic [16:0] EIGHT_F = 17'd52429;
   localparam logic [16:0] LERP_A  = 17'd45875;
   localparam logic [14:0] LERP_B  = 15'd19661;
   localparam logic [31:0] AMP_RESET = 32'd65536;

   localparam int NOISE_DEN = 10000;
   localparam int NOISE_ONE = 65536;

   localparam logic [16:0] NOISE_U_TAB [16] = '{
      17'((312  * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((7812 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((4062 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((9687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((2187 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((5937 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((3437 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((7187 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((937  * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((8437 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((4687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((9062 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((1562 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((5312 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((2812 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((9687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN)
   };

   localparam logic [16:0] NOISE_V_TAB [16] = '{
      17'((5625 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((1562 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((9062 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((4687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((312  * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((2812 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((7187 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((9687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((4062 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((8437 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((937  * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((5312 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((7812 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((312  * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((4687 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN),
      17'((2187 * NOISE_ONE + NOISE_DEN / 2) / NOISE_DEN)
   };

   typedef enum logic [0:0] {
      CSR_BASE_SEED  = 1'b0,
      CSR_JITTER_AMP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        seed;
      logic               regen;
      logic               nz;
      logic [16:0]        bu;
      logic [16:0]        bv;
      logic signed [24:0] jx;
      logic signed [24:0] jy;
      logic [18:0]        ang;
      logic [16:0]        scl;
   } front_type;

   function automatic logic [31:0] mix32(input logic [31:0] s, input logic [31:0] v);
      return s ^ (v + GOLDEN + {s[25:0], 6'b0} + {2'b0, s[31:2]});
   endfunction

   // floor(x / (2^24 - 1)) for x below 2^43 - 2^19
   function automatic logic [18:0] unit_div(input logic [42:0] x);
      logic [18:0] q0;
      logic [24:0] r;
      q0 = x[42:24];
      r  = {1'b0, x[23:0]} + {6'b0, q0};
      return q0 + 19'(r >= {1'b0, UNIT_DIV});
   endfunction

endpackage

>>> src/ssjh_isqrt.sv
// pipelined integer square root, one result bit per stage
module ssjh_isqrt import ssjh_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [47:0] val_in,
   output logic [23:0] root_out
);

   logic [25:0] rem_ff  [SQRT_STAGES];
   logic [23:0] root_ff [SQRT_STAGES];
   logic [47:0] rest_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      logic [25:0] rem_cur;
      logic [23:0] root_cur;
      logic [47:0] rest_cur;
      logic [27:0] shifted;
      logic [27:0] trial;
      logic        ge;

      if (g == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rest_cur = val_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
         assign rest_cur = rest_ff[g-1];
      end

      assign shifted = {rem_cur, rest_cur[47:46]};
      assign trial   = {2'b00, root_cur, 2'b01};
      assign ge      = shifted >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= ge ? 26'(shifted - trial) : shifted[25:0];
            root_ff[g] <= {root_cur[22:0], ge};
            rest_ff[g] <= {rest_cur[45:0], 2'b00};
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];

endmodule

>>> src/ssjh_div.sv
// pipelined restoring divider, seventeen quotient bits, one per stage
module ssjh_div import ssjh_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [39:0] num_in,
   input  logic [23:0] den_in,
   output logic [16:0] quo_out
);

   logic [23:0] rem_ff  [DIV_STAGES];
   logic [16:0] rest_ff [DIV_STAGES];
   logic [23:0] den_ff  [DIV_STAGES];
   logic [16:0] quo_ff  [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [23:0] rem_cur;
      logic [16:0] rest_cur;
      logic [23:0] den_cur;
      logic [16:0] quo_cur;
      logic [24:0] sh;
      logic        ge;

      if (g == 0) begin : g_first
         assign rem_cur  = {1'b0, num_in[39:17]};
         assign rest_cur = num_in[16:0];
         assign den_cur  = den_in;
         assign quo_cur  = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[g-1];
         assign rest_cur = rest_ff[g-1];
         assign den_cur  = den_ff[g-1];
         assign quo_cur  = quo_ff[g-1];
      end

      assign sh = {rem_cur, rest_cur[16]};
      assign ge = sh >= {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= ge ? 24'(sh - {1'b0, den_cur}) : sh[23:0];
            rest_ff[g] <= {rest_cur[15:0], 1'b0};
            den_ff[g]  <= den_cur;
            quo_ff[g]  <= {quo_cur[15:0], ge};
         end
      end
   end

   assign quo_out = quo_ff[DIV_STAGES-1];

endmodule

>>> src/splat_stroke_jitter_hash_core.sv
// top level of the splat stroke jitter hash core
// Takes one splat per cycle and returns its stroke transaction in the same order; the
// latency is set by the normal-length path, a 24-stage square root followed by a
// 17-stage divider, and all other fields ride along in a matching delay line. The
// whole pipeline advances together: while a result waits with rsp_ready low, every
// stage holds and req_ready is low, so nothing is lost or repeated. Configuration
// writes take effect at once and must only be made while the pipeline is empty.
module splat_stroke_jitter_hash_core import ssjh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_splat_index,
   input  logic [7:0]         req_lod_level,
   input  logic [31:0]        req_prior_seed,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_new_seed,
   output logic               rsp_regenerated,
   output logic [16:0]        rsp_noise_u,
   output logic [16:0]        rsp_noise_v,
   output logic signed [24:0] rsp_jitter_x,
   output logic signed [24:0] rsp_jitter_y,
   output logic signed [18:0] rsp_brush_angle,
   output logic [16:0]        rsp_brush_size,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [31:0]        csr_wdata
);

   logic        adv;
   logic [31:0] base_seed_ff;
   logic [23:0] jitter_amp_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;

   // stage 1
   logic [31:0] p1_prior_ff;
   logic        p1_isprior_ff;
   logic [7:0]  p1_lvl_ff;
   logic [31:0] p1_lvlprod_ff;
   logic [31:0] p1_seed1_ff;
   logic [30:0] p1_sqx_ff, p1_sqy_ff, p1_sqz_ff;
   logic [15:0] p1_ay_ff;
   logic signed [31:0] sqx_w, sqy_w, sqz_w;
   logic [15:0] ay_w;

   // stage 2
   logic        p2_isprior_ff;
   logic [31:0] p2_pseed_ff;
   logic [31:0] p2_seed_ff;
   logic [31:0] p2_ss_ff;
   logic [15:0] p2_ay_ff;

   // stage 3
   logic [31:0] p3_seed_ff;
   logic        p3_regen_ff;
   logic        p3_nz_ff;
   logic [3:0]  p3_nh_ff;
   logic [31:0] p3_jh_ff;
   logic [23:0] p3_ah_ff;
   logic [23:0] p3_sh_ff;
   logic [31:0] out_seed_w;

   // stage 4
   logic [31:0] p4_seed_ff;
   logic        p4_regen_ff;
   logic        p4_nz_ff;
   logic [31:0] p4_jyh_ff;
   logic [16:0] p4_bu_ff, p4_bv_ff;
   logic [16:0] p4_ux_ff;
   logic [42:0] p4_angp_ff;
   logic [42:0] p4_sclp_ff;
   logic [18:0] ux_q_w;

   // stage 5
   logic [31:0] p5_seed_ff;
   logic        p5_regen_ff;
   logic        p5_nz_ff;
   logic [16:0] p5_bu_ff, p5_bv_ff, p5_ux_ff, p5_uy_ff;
   logic [18:0] p5_ang_ff;
   logic [16:0] p5_scl_ff;
   logic [18:0] uy_q_w, ang_q_w, scl_q_w;

   // stage 6
   logic [31:0] p6_seed_ff;
   logic        p6_regen_ff;
   logic        p6_nz_ff;
   logic [16:0] p6_bu_ff, p6_bv_ff;
   logic [18:0] p6_ang_ff;
   logic [16:0] p6_scl_ff;
   logic signed [18:0] p6_ox_ff, p6_oy_ff;

   // stage 7
   logic [31:0] p7_seed_ff;
   logic        p7_regen_ff;
   logic        p7_nz_ff;
   logic [16:0] p7_bu_ff, p7_bv_ff;
   logic [18:0] p7_ang_ff;
   logic [16:0] p7_scl_ff;
   logic signed [43:0] p7_jxp_ff, p7_jyp_ff;
   logic signed [43:0] jxr_w, jyr_w;

   // stage 8 and the delay line behind it
   front_type front_in;
   front_type front_ff;
   front_type dly_ff [FRONT_DLY];

   // normal length path
   logic [15:0] ay_d_ff [SQRT_STAGES];
   logic [23:0] len_w;
   logic [39:0] num_w;
   logic [16:0] quo_w;
   logic [16:0] rclamp_w;
   logic [31:0] kp_ff;
   logic [16:0] k_ff;
   logic signed [42:0] px_ff, py_ff;
   logic signed [42:0] pxr_w, pyr_w;

   assign adv       = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seed_ff  <= '0;
         jitter_amp_ff <= AMP_RESET[23:0];
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_SEED:  base_seed_ff  <= csr_wdata;
            CSR_JITTER_AMP: jitter_amp_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   assign sqx_w = req_normal_x * req_normal_x;
   assign sqy_w = req_normal_y * req_normal_y;
   assign sqz_w = req_normal_z * req_normal_z;
   assign ay_w  = req_normal_y[15] ? 16'(-req_normal_y) : req_normal_y;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_prior_ff   <= req_prior_seed;
         p1_isprior_ff <= req_prior_seed != '0;
         p1_lvl_ff     <= req_lod_level;
         p1_lvlprod_ff <= 32'({24'b0, req_lod_level} * LVL_MUL);
         p1_seed1_ff   <= mix32(base_seed_ff, req_splat_index + 32'd1);
         p1_sqx_ff     <= sqx_w[30:0];
         p1_sqy_ff     <= sqy_w[30:0];
         p1_sqz_ff     <= sqz_w[30:0];
         p1_ay_ff      <= ay_w;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_isprior_ff <= p1_isprior_ff;
         p2_pseed_ff   <= mix32(p1_prior_ff, p1_lvlprod_ff);
         p2_seed_ff    <= mix32(p1_seed1_ff, {24'b0, p1_lvl_ff} + 32'd1);
         p2_ss_ff      <= {1'b0, p1_sqx_ff} + {1'b0, p1_sqy_ff} + {1'b0, p1_sqz_ff};
         p2_ay_ff      <= p1_ay_ff;
      end
   end

   assign out_seed_w = p2_isprior_ff ? p2_pseed_ff : p2_seed_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_seed_ff  <= (out_seed_w == '0) ? 32'd1 : out_seed_w;
         p3_regen_ff <= !p2_isprior_ff;
         p3_nz_ff    <= p2_ss_ff != '0;
         p3_nh_ff    <= 4'(mix32(p2_seed_ff, SALT_NOISE));
         p3_jh_ff    <= mix32(p2_seed_ff, SALT_JIT);
         p3_ah_ff    <= 24'(mix32(p2_seed_ff, SALT_ANG));
         p3_sh_ff    <= 24'(mix32(p2_seed_ff, SALT_SCL));
      end
   end

   assign ux_q_w = unit_div({3'b0, p3_jh_ff[23:0], 16'b0} + {19'b0, HALF_UNIT_DIV});

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_seed_ff  <= p3_seed_ff;
         p4_regen_ff <= p3_regen_ff;
         p4_nz_ff    <= p3_nz_ff;
         p4_jyh_ff   <= mix32(p3_jh_ff, SALT_JY);
         p4_bu_ff    <= NOISE_U_TAB[p3_nh_ff];
         p4_bv_ff    <= NOISE_V_TAB[p3_nh_ff];
         p4_ux_ff    <= ux_q_w[16:0];
         p4_angp_ff  <= {19'b0, p3_ah_ff} * {24'b0, TAU_F} + {19'b0, HALF_UNIT_DIV};
         p4_sclp_ff  <= {19'b0, p3_sh_ff} * {26'b0, EIGHT_F} + {19'b0, HALF_UNIT_DIV};
      end
   end

   assign uy_q_w  = unit_div({3'b0, p4_jyh_ff[23:0], 16'b0} + {19'b0, HALF_UNIT_DIV});
   assign ang_q_w = unit_div(p4_angp_ff);
   assign scl_q_w = unit_div(p4_sclp_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_seed_ff  <= p4_seed_ff;
         p5_regen_ff <= p4_regen_ff;
         p5_nz_ff    <= p4_nz_ff;
         p5_bu_ff    <= p4_bu_ff;
         p5_bv_ff    <= p4_bv_ff;
         p5_ux_ff    <= p4_ux_ff;
         p5_uy_ff    <= uy_q_w[16:0];
         p5_ang_ff   <= ang_q_w - PI_F;
         p5_scl_ff   <= SIX_F + scl_q_w[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_seed_ff  <= p5_seed_ff;
         p6_regen_ff <= p5_regen_ff;
         p6_nz_ff    <= p5_nz_ff;
         p6_bu_ff    <= p5_bu_ff;
         p6_bv_ff    <= p5_bv_ff;
         p6_ang_ff   <= p5_ang_ff;
         p6_scl_ff   <= p5_scl_ff;
         p6_ox_ff    <= $signed({2'b0, p5_bu_ff} + {1'b0, p5_ux_ff, 1'b0} - 19'd98304);
         p6_oy_ff    <= $signed({2'b0, p5_bv_ff} + {1'b0, p5_uy_ff, 1'b0} - 19'd98304);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_seed_ff  <= p6_seed_ff;
         p7_regen_ff <= p6_regen_ff;
         p7_nz_ff    <= p6_nz_ff;
         p7_bu_ff    <= p6_bu_ff;
         p7_bv_ff    <= p6_bv_ff;
         p7_ang_ff   <= p6_ang_ff;
         p7_scl_ff   <= p6_scl_ff;
         p7_jxp_ff   <= 44'(p6_ox_ff * $signed({1'b0, jitter_amp_ff}));
         p7_jyp_ff   <= 44'(p6_oy_ff * $signed({1'b0, jitter_amp_ff}));
      end
   end

   // round half away from zero by 2^17
   assign jxr_w = p7_jxp_ff + (p7_jxp_ff[43] ? 44'sd65535 : 44'sd65536);
   assign jyr_w = p7_jyp_ff + (p7_jyp_ff[43] ? 44'sd65535 : 44'sd65536);

   always_comb begin
      front_in.seed  = p7_seed_ff;
      front_in.regen = p7_regen_ff;
      front_in.nz    = p7_nz_ff;
      front_in.bu    = p7_regen_ff ? p7_bu_ff : '0;
      front_in.bv    = p7_regen_ff ? p7_bv_ff : '0;
      front_in.jx    = p7_regen_ff ? jxr_w[41:17] : '0;
      front_in.jy    = p7_regen_ff ? jyr_w[41:17] : '0;
      front_in.ang   = p7_regen_ff ? p7_ang_ff : '0;
      front_in.scl   = p7_regen_ff ? p7_scl_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff <= front_in;
         dly_ff[0] <= front_ff;
         for (int i = 1; i < FRONT_DLY; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ay_d_ff[0] <= p2_ay_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            ay_d_ff[i] <= ay_d_ff[i-1];
         end
      end
   end

   ssjh_isqrt u_isqrt (
      .clock    (clock),
      .adv      (adv),
      .val_in   ({p2_ss_ff, 16'b0}),
      .root_out (len_w)
   );

   assign num_w = {ay_d_ff[SQRT_STAGES-1], 24'b0} + {17'b0, len_w[23:1]};

   ssjh_div u_div (
      .clock   (clock),
      .adv     (adv),
      .num_in  (num_w),
      .den_in  (len_w),
      .quo_out (quo_w)
   );

   assign rclamp_w = (quo_w > ONE_F) ? ONE_F : quo_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         kp_ff <= 32'({15'b0, rclamp_w} * {17'b0, LERP_B}) + 32'd32768;
         k_ff  <= LERP_A + {1'b0, kp_ff[31:16]};
         px_ff <= 43'(dly_ff[FRONT_DLY-2].jx * $signed({1'b0, k_ff}));
         py_ff <= 43'(dly_ff[FRONT_DLY-2].jy * $signed({1'b0, k_ff}));
      end
   end

   // round half away from zero by 2^16
   assign pxr_w = px_ff + (px_ff[42] ? 43'sd32767 : 43'sd32768);
   assign pyr_w = py_ff + (py_ff[42] ? 43'sd32767 : 43'sd32768);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_new_seed     <= dly_ff[FRONT_DLY-1].seed;
         rsp_regenerated  <= dly_ff[FRONT_DLY-1].regen;
         rsp_noise_u      <= dly_ff[FRONT_DLY-1].bu;
         rsp_noise_v      <= dly_ff[FRONT_DLY-1].bv;
         rsp_jitter_x     <= dly_ff[FRONT_DLY-1].nz ? pxr_w[40:16] : dly_ff[FRONT_DLY-1].jx;
         rsp_jitter_y     <= dly_ff[FRONT_DLY-1].nz ? pyr_w[40:16] : dly_ff[FRONT_DLY-1].jy;
         rsp_brush_angle  <= $signed(dly_ff[FRONT_DLY-1].ang);
         rsp_brush_size   <= dly_ff[FRONT_DLY-1].scl;
      end
   end

endmodule
